[hdl/assert_macros.svh]
// Assertion macros used by the allocator back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define TCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define TCA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hdl/tca_pkg.sv]
// Types, codes and helpers of the tiered connection allocator.
package tca_pkg;

  typedef enum logic [1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_BLOCK   = 2'd2,
    KIND_TICK    = 2'd3
  } kind_e;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT   = 2'd1;
  localparam logic [1:0] STATUS_FREE_SLOT = 2'd2;

  localparam logic [2:0] CFG_RETRY     = 3'd0;
  localparam logic [2:0] CFG_LEVELS    = 3'd1;
  localparam logic [2:0] CFG_ACTIVE    = 3'd2;
  localparam logic [2:0] CFG_MAX_CONNS = 3'd3;
  localparam logic [2:0] CFG_GROUPS    = 3'd4;
  localparam logic [2:0] CFG_OPTIONAL  = 3'd5;

  localparam logic [15:0] RETRY_RESET = 16'd10;
  localparam logic [15:0] LFSR_RESET  = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS   = 16'hB400;

  typedef struct packed {
    logic [15:0] retry_seconds;
    logic [31:0] server_levels;
    logic [7:0]  server_active_mask;
    logic [31:0] server_max_conns;
    logic [31:0] server_groups;
    logic [7:0]  server_optional_mask;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  start_level;
    logic        want_valid;
    logic [2:0]  want_server;
    logic [7:0]  ignore_mask;
    logic [5:0]  release_slot;
    logic        still_connected;
    logic [2:0]  target_server;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] granted_slot;
    logic [2:0] granted_server;
    logic [2:0] granted_level;
  } result_t;

  // Four-bit field of server idx; servers past the eighth read as zero.
  function automatic logic [3:0] cfg_nib(logic [31:0] r, logic [3:0] idx);
    logic [3:0] v;
    v = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (idx == 4'(i)) v = r[4*i +: 4];
    end
    return v;
  endfunction

  function automatic logic cfg_bit(logic [7:0] r, logic [3:0] idx);
    logic v;
    v = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (idx == 4'(i)) v = r[i];
    end
    return v;
  endfunction

  function automatic logic [4:0] pop16(logic [15:0] v);
    logic [4:0] c;
    c = 5'd0;
    for (int i = 0; i < 16; i++) c = c + 5'(v[i]);
    return c;
  endfunction

  function automatic logic [15:0] lfsr_next(logic [15:0] w);
    return (w >> 1) ^ (w[0] ? LFSR_TAPS : 16'd0);
  endfunction

endpackage

[hdl/tca_front.sv]
// Front end: accepts request transactions, decodes the kind, queues them.
module tca_front
  import tca_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  output item_t       item_o,
  output logic        item_valid_o,
  input  logic        item_pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  item_t      dec;
  logic       push;

  always_comb begin
    dec.kind            = kind_e'(s_axis_tuser);
    dec.start_level     = s_axis_tdata[2:0];
    dec.want_valid      = s_axis_tdata[3];
    dec.want_server     = s_axis_tdata[6:4];
    dec.ignore_mask     = s_axis_tdata[14:7];
    dec.release_slot    = s_axis_tdata[20:15];
    dec.still_connected = s_axis_tdata[21];
    dec.target_server   = s_axis_tdata[24:22];
  end

  assign s_axis_tready = (fill_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = (fill_q != 2'd0);
  assign item_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (item_pop_i) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(item_pop_i);
    end
  end

endmodule

[hdl/tca_back.sv]
// Back end: executes queued transactions against slot and block state.
`include "assert_macros.svh"
module tca_back
  import tca_pkg::*;
#(
  parameter int SERVERS          = 8,
  parameter int SLOTS_PER_SERVER = 8,
  parameter int TIME_BITS        = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    item_valid_i,
  output logic    item_pop_o,
  output result_t res_o,
  output logic    res_valid_o,
  input  logic    res_ready_i
);

  localparam int LIVE   = (SERVERS < 8) ? SERVERS : 8;
  localparam int TOTAL  = SERVERS * SLOTS_PER_SERVER;
  localparam int SRV_W  = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int K_W    = (SLOTS_PER_SERVER > 1) ? $clog2(SLOTS_PER_SERVER) : 1;
  localparam int SLOT_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CNT_W  = $clog2(TOTAL + 1);
  localparam int SPS    = SLOTS_PER_SERVER;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RANK  = 4'd1;
  localparam logic [3:0] S_LVL   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_EVAL  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_WALKS = 4'd6;
  localparam logic [3:0] S_WALKK = 4'd7;

  logic [3:0]           state_q;
  item_t                acq_q;
  result_t              res_q;
  logic                 res_valid_q;
  logic [TOTAL-1:0]     busy_q, open_q;
  logic [SERVERS-1:0]   blk_act_q;
  logic [TIME_BITS-1:0] blk_start_q [SERVERS];
  logic [TIME_BITS-1:0] now_q;
  logic [15:0]          lfsr_q;
  logic [2:0]           norm_q [SERVERS];
  logic [SERVERS-1:0]   normv_q;
  logic [2:0]           maxn_q;
  logic [3:0]           lvl_q;
  logic [SRV_W-1:0]     srv_q;
  logic [K_W-1:0]       k_q;
  logic [SPS-1:0]       cand_q [SERVERS];
  logic [CNT_W-1:0]     count_q;
  logic                 nfree_q, skip_q;
  logic [CNT_W:0]       rem_q;
  logic [15:0]          dvd_q;
  logic [3:0]           div_cnt_q;

  // ranking, from configuration only
  logic [2:0]         rk_n [SERVERS];
  logic [SERVERS-1:0] rk_v;
  logic [2:0]         rk_max;

  always_comb begin
    logic [3:0]  minl, lv;
    logic [15:0] qual, below;
    logic        ql;
    minl = 4'hF;
    qual = 16'd0;
    for (int i = 0; i < LIVE; i++) begin
      lv = cfg_nib(cfg_i.server_levels, 4'(i));
      if (lv < minl) minl = lv;
    end
    for (int i = 0; i < LIVE; i++) begin
      lv = cfg_nib(cfg_i.server_levels, 4'(i));
      ql = (cfg_bit(cfg_i.server_active_mask, 4'(i)) &&
            cfg_nib(cfg_i.server_max_conns, 4'(i)) != 4'd0) || (lv == minl);
      if (ql) qual[lv] = 1'b1;
    end
    for (int i = 0; i < SERVERS; i++) begin
      lv    = cfg_nib(cfg_i.server_levels, 4'(i));
      below = qual & ((16'd1 << lv) - 16'd1);
      rk_n[i] = 3'(pop16(below));
      rk_v[i] = (i < LIVE) &&
                ((cfg_bit(cfg_i.server_active_mask, 4'(i)) &&
                  cfg_nib(cfg_i.server_max_conns, 4'(i)) != 4'd0) || (lv == minl));
    end
    rk_max = 3'(pop16(qual) - 5'd1);
  end

  // one server of the level scan
  logic [SLOT_W-1:0]    base_idx;
  logic [3:0]           srv4;
  logic [SPS-1:0]       sc_free, sc_base, sc_pass, sc_cand;
  logic                 sc_blocked, sc_cleared, sc_nonskip;
  logic [CNT_W-1:0]     sc_pc;
  logic [TIME_BITS-1:0] sc_diff;

  always_comb begin
    logic       usable, want_ok, ign, seen;
    logic [3:0] g_srv, g_want, mc;
    srv4     = 4'(srv_q);
    base_idx = SLOT_W'(int'(srv_q) * SPS);
    mc       = cfg_nib(cfg_i.server_max_conns, srv4);
    g_srv    = cfg_nib(cfg_i.server_groups, srv4);
    g_want   = cfg_nib(cfg_i.server_groups, {1'b0, acq_q.want_server});
    usable   = cfg_bit(cfg_i.server_active_mask, srv4) && normv_q[srv_q] &&
               (norm_q[srv_q] == lvl_q[2:0]);
    want_ok  = !acq_q.want_valid || (srv4 == {1'b0, acq_q.want_server}) ||
               (g_want != 4'd0 && g_want == g_srv);
    sc_diff    = now_q - blk_start_q[srv_q];
    sc_blocked = blk_act_q[srv_q] && (sc_diff < TIME_BITS'(cfg_i.retry_seconds));
    for (int k = 0; k < SPS; k++) begin
      sc_free[k] = usable && (4'(k) < mc) && !busy_q[base_idx + SLOT_W'(k)];
      sc_base[k] = sc_free[k] && want_ok;
    end
    // a blocked server is unblocked by its first open candidate; later ones pass
    for (int k = 0; k < SPS; k++) begin
      seen = 1'b0;
      for (int j = 0; j <= k; j++) begin
        if (sc_base[j] && open_q[base_idx + SLOT_W'(j)]) seen = 1'b1;
      end
      sc_pass[k] = sc_base[k] && (!sc_blocked || seen);
    end
    sc_cleared = |sc_pass;
    ign = 1'b0;
    for (int i = 0; i < LIVE; i++) begin
      if (acq_q.ignore_mask[i]) begin
        if (srv_q == SRV_W'(i)) ign = 1'b1;
        if (g_srv != 4'd0 && cfg_nib(cfg_i.server_groups, 4'(i)) == g_srv &&
            normv_q[i] && norm_q[i] == norm_q[srv_q]) ign = 1'b1;
      end
    end
    sc_cand = (!acq_q.want_valid && ign) ? '0 : sc_pass;
    sc_pc   = '0;
    for (int k = 0; k < SPS; k++) sc_pc = sc_pc + CNT_W'(sc_cand[k]);
    sc_nonskip = (int'(srv_q) < LIVE) && usable &&
                 !(cfg_bit(cfg_i.server_optional_mask, srv4) &&
                   sc_blocked && !sc_cleared);
  end

  // walk and division helpers
  logic [CNT_W-1:0]  walk_pc;
  logic [SLOT_W-1:0] walk_idx;
  logic              grant_hit;
  logic [CNT_W:0]    div_trial;

  always_comb begin
    walk_pc = '0;
    for (int k = 0; k < SPS; k++) walk_pc = walk_pc + CNT_W'(cand_q[srv_q][k]);
  end
  assign walk_idx  = base_idx + SLOT_W'(k_q);
  assign grant_hit = (state_q == S_WALKK) && cand_q[srv_q][k_q] && (rem_q == '0);
  assign div_trial = {rem_q[CNT_W-1:0], dvd_q[15]};

  logic take, done_fail;
  logic [SLOT_W-1:0] rel_idx;
  logic [SRV_W-1:0]  tgt_idx;

  assign take       = (state_q == S_IDLE) && item_valid_i && !res_valid_q;
  assign item_pop_o = take;
  assign rel_idx    = SLOT_W'(item_i.release_slot);
  assign tgt_idx    = SRV_W'(item_i.target_server);
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;
  assign done_fail   = ((state_q == S_LVL) && (lvl_q > {1'b0, maxn_q})) ||
                       ((state_q == S_EVAL) && (count_q == '0) && (!nfree_q || !skip_q));

  always_ff @(posedge clk_i) begin
    if (take) acq_q <= item_i;
    if (state_q == S_SCAN) cand_q[srv_q] <= sc_cand;
    if (state_q == S_RANK) begin
      norm_q <= rk_n;
      maxn_q <= rk_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      busy_q      <= '0;
      open_q      <= '0;
      blk_act_q   <= '0;
      for (int i = 0; i < SERVERS; i++) blk_start_q[i] <= '0;
      now_q       <= '0;
      lfsr_q      <= LFSR_RESET;
      normv_q     <= '0;
      lvl_q       <= '0;
      srv_q       <= '0;
      k_q         <= '0;
      count_q     <= '0;
      nfree_q     <= 1'b0;
      skip_q      <= 1'b1;
      rem_q       <= '0;
      dvd_q       <= '0;
      div_cnt_q   <= '0;
    end else begin
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      if (done_fail) begin
        res_q       <= '{status: STATUS_NO_SLOT, default: '0};
        res_valid_q <= 1'b1;
        state_q     <= S_IDLE;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (take) begin
              unique case (item_i.kind)
                KIND_ACQUIRE: begin
                  lvl_q   <= {1'b0, item_i.start_level};
                  state_q <= S_RANK;
                end
                KIND_RELEASE: begin
                  res_valid_q <= 1'b1;
                  if (9'(item_i.release_slot) < 9'(TOTAL) && busy_q[rel_idx]) begin
                    busy_q[rel_idx] <= 1'b0;
                    open_q[rel_idx] <= item_i.still_connected;
                    res_q <= '{status: STATUS_OK, default: '0};
                  end else begin
                    res_q <= '{status: STATUS_FREE_SLOT, default: '0};
                  end
                end
                KIND_BLOCK: begin
                  res_valid_q <= 1'b1;
                  res_q       <= '{status: STATUS_OK, default: '0};
                  if (5'(item_i.target_server) < 5'(SERVERS)) begin
                    blk_act_q[tgt_idx]   <= 1'b1;
                    blk_start_q[tgt_idx] <= now_q;
                  end
                end
                KIND_TICK: begin
                  res_valid_q <= 1'b1;
                  res_q       <= '{status: STATUS_OK, default: '0};
                  now_q       <= now_q + TIME_BITS'(1);
                end
                default: ;
              endcase
            end
          end
          S_RANK: begin
            normv_q <= rk_v;
            state_q <= S_LVL;
          end
          S_LVL: begin
            srv_q   <= '0;
            count_q <= '0;
            nfree_q <= 1'b0;
            skip_q  <= 1'b1;
            state_q <= S_SCAN;
          end
          S_SCAN: begin
            count_q <= count_q + sc_pc;
            if (|sc_free) nfree_q <= 1'b1;
            if (sc_nonskip) skip_q <= 1'b0;
            if (sc_cleared) blk_act_q[srv_q] <= 1'b0;
            if (srv_q == SRV_W'(SERVERS - 1)) state_q <= S_EVAL;
            else srv_q <= srv_q + SRV_W'(1);
          end
          S_EVAL: begin
            if (count_q != '0) begin
              lfsr_q    <= lfsr_next(lfsr_q);
              dvd_q     <= lfsr_next(lfsr_q);
              rem_q     <= '0;
              div_cnt_q <= 4'd15;
              state_q   <= S_DIV;
            end else begin
              lvl_q   <= lvl_q + 4'd1;
              state_q <= S_LVL;
            end
          end
          S_DIV: begin
            // restoring division, one quotient bit per cycle
            dvd_q <= {dvd_q[14:0], 1'b0};
            if (div_trial >= {1'b0, count_q}) rem_q <= div_trial - {1'b0, count_q};
            else rem_q <= div_trial;
            div_cnt_q <= div_cnt_q - 4'd1;
            if (div_cnt_q == 4'd0) begin
              srv_q   <= '0;
              state_q <= S_WALKS;
            end
          end
          S_WALKS: begin
            if (rem_q < {1'b0, walk_pc}) begin
              k_q     <= '0;
              state_q <= S_WALKK;
            end else begin
              rem_q <= rem_q - {1'b0, walk_pc};
              srv_q <= srv_q + SRV_W'(1);
            end
          end
          S_WALKK: begin
            if (grant_hit) begin
              busy_q[walk_idx] <= 1'b1;
              res_q <= '{status: STATUS_OK, granted_slot: 6'(walk_idx),
                         granted_server: 3'(srv_q), granted_level: 3'(lvl_q)};
              res_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              if (cand_q[srv_q][k_q]) rem_q <= rem_q - (CNT_W + 1)'(1);
              k_q <= k_q + K_W'(1);
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  `TCA_ASSERT(a_div_nonzero, (state_q == S_DIV) |-> (count_q != '0), "modulo by zero count")
  `TCA_ASSERT(a_result_idle, res_valid_q |-> (state_q == S_IDLE), "result while busy")
  `TCA_ASSERT_NEVER(a_grant_free, grant_hit && busy_q[walk_idx], "granted slot already busy")

endmodule

[hdl/tiered_connection_allocator_core.sv]
// Top level of the tiered connection allocator: ports, configuration, front and back.
//
//  channel  | direction | handshake             | payload
//  s_axis   | in        | s_axis_tvalid/tready  | tdata request fields, tuser kind
//  m_axis   | out       | m_axis_tvalid/tready  | tdata grant fields, tuser status
//  cfg      | in        | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//
// Release, block and tick: result registered at the edge that pops the queue head.
// Acquire: pop, rank, then per level searched a setup, a scan of every server and an
// evaluation; then the LFSR modulo (restoring divider, one bit a cycle) and a walk
// over the servers, then over the slots of the chosen server, to the grant.
// A waiting result holds the back end; the two-entry queue keeps taking requests until full.
// Reset is asynchronous, active low; all slots free, no blocks, LFSR at 0xACE1.
module tiered_connection_allocator_core
  import tca_pkg::*;
#(
  parameter int SERVERS          = 8,
  parameter int SLOTS_PER_SERVER = 8,
  parameter int TIME_BITS        = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_level[2:0], want_valid[3], want_server[6:4], ignore_mask[14:7],
  // release_slot[20:15], still_connected[21], target_server[24:22]
  input  logic [31:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // granted_slot[5:0], granted_server[8:6], granted_level[11:9]
  output logic [15:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t    cfg_q;
  item_t   item;
  logic    item_valid, item_pop;
  result_t res;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{retry_seconds: RETRY_RESET, default: '0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RETRY:     cfg_q.retry_seconds        <= cfg_data_i[15:0];
        CFG_LEVELS:    cfg_q.server_levels        <= cfg_data_i;
        CFG_ACTIVE:    cfg_q.server_active_mask   <= cfg_data_i[7:0];
        CFG_MAX_CONNS: cfg_q.server_max_conns     <= cfg_data_i;
        CFG_GROUPS:    cfg_q.server_groups        <= cfg_data_i;
        CFG_OPTIONAL:  cfg_q.server_optional_mask <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  tca_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_pop_i    (item_pop)
  );

  tca_back #(
    .SERVERS          (SERVERS),
    .SLOTS_PER_SERVER (SLOTS_PER_SERVER),
    .TIME_BITS        (TIME_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .res_o        (res),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, res.granted_level, res.granted_server, res.granted_slot};
  assign m_axis_tuser = res.status;

endmodule
